// ----- rtl/lkv_pkg.sv -----
// Shared types, sizes and codes for the LRU key/value table.
// Used by every module of the block; depends on nothing.
package lkv_pkg;

  localparam int ENTRIES     = 16;
  localparam int KEY_BYTES   = 24;
  localparam int VALUE_BYTES = 32;
  localparam int KEY_WORDS   = 3;
  localparam int VALUE_WORDS = 4;
  localparam int MAX_OUT     = 16;

  localparam int KEY_W   = KEY_WORDS * 64;
  localparam int VALUE_W = VALUE_WORDS * 64;
  localparam int STAMP_W = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int DUMP_N  = (ENTRIES < MAX_OUT) ? ENTRIES : MAX_OUT;

  localparam int SLOT_OUT_W  = 4;
  localparam int COUNT_OUT_W = 5;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [1:0] {
    OP_STORE  = 2'd0,
    OP_DUMP   = 2'd1,
    OP_SELECT = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_UPDATED    = 3'd0,
    ST_ADDED      = 3'd1,
    ST_REPLACED   = 3'd2,
    ST_DUMP_ENTRY = 3'd3,
    ST_DUMP_EMPTY = 3'd4,
    ST_SAME_CAM   = 3'd5,
    ST_CAM_CHANGE = 3'd6,
    ST_CLEARED    = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_MIN,
    S_WRITE,
    S_DUMP
  } state_t;

  typedef struct packed {
    key_t   key;
    value_t value;
    stamp_t stamp;
  } row_t;

  typedef struct packed {
    idx_t rd_addr;
    logic wr_en;
    idx_t wr_addr;
    row_t wr_row;
  } mem_req_t;

  function automatic logic [SLOT_OUT_W-1:0] slot_out(input idx_t idx);
    logic [IDX_W+SLOT_OUT_W-1:0] ext;
    ext = {{SLOT_OUT_W{1'b0}}, idx};
    return ext[SLOT_OUT_W-1:0];
  endfunction

  function automatic logic [COUNT_OUT_W-1:0] count_out(input cnt_t cnt);
    logic [CNT_W+COUNT_OUT_W-1:0] ext;
    ext = {{COUNT_OUT_W{1'b0}}, cnt};
    return ext[COUNT_OUT_W-1:0];
  endfunction

endpackage

// ----- rtl/lru_key_value_table.sv -----
// A command is taken when start is high and busy is low. A store walks the
// live entries one per cycle through the single memory read port looking for
// its key and stops at a match; on a full table with no match it walks all
// entries again for the oldest stamp. A dump gives one result per listed
// entry, or a single empty result; select and clear give one result each.
// Each result is held on the result ports for one cycle with result_valid
// high and cannot be stalled; last marks the final beat of a command.
// Depends on lkv_pkg, lkv_norm and lkv_mem.
module lru_key_value_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [7:0]  camera_id,
  input  logic [63:0] key_word0,
  input  logic [63:0] key_word1,
  input  logic [63:0] key_word2,
  input  logic [63:0] value_word0,
  input  logic [63:0] value_word1,
  input  logic [63:0] value_word2,
  input  logic [63:0] value_word3,
  output logic        result_valid,
  output logic [2:0]  status,
  output logic [3:0]  slot,
  output logic [4:0]  entry_count,
  output logic [63:0] out_key0,
  output logic [63:0] out_key1,
  output logic [63:0] out_key2,
  output logic [63:0] out_value0,
  output logic [63:0] out_value1,
  output logic [63:0] out_value2,
  output logic [63:0] out_value3,
  output logic        last
);

  lkv_pkg::state_t  state, state_next;
  lkv_pkg::op_t     op, op_next;
  logic [7:0]       cam, cam_next;
  lkv_pkg::key_t    key_r, key_r_next;
  lkv_pkg::value_t  val_r, val_r_next;
  lkv_pkg::cnt_t    live_count, live_count_next;
  lkv_pkg::stamp_t  stamp_counter, stamp_counter_next;
  logic [7:0]       active_camera, active_camera_next;
  lkv_pkg::idx_t    idx, idx_next;
  lkv_pkg::stamp_t  best, best_next;
  lkv_pkg::idx_t    slot_r, slot_r_next;
  lkv_pkg::status_t wr_status, wr_status_next;

  lkv_pkg::key_t    norm_key;
  lkv_pkg::value_t  norm_val;
  lkv_pkg::mem_req_t req;
  lkv_pkg::row_t    rd_row;

  logic             emit;
  lkv_pkg::status_t e_status;
  lkv_pkg::idx_t    e_slot;
  lkv_pkg::key_t    e_key;
  lkv_pkg::value_t  e_val;
  logic             e_last;
  lkv_pkg::cnt_t    idx_inc;

  lkv_norm u_norm (
    .key_in    ({key_word2, key_word1, key_word0}),
    .value_in  ({value_word3, value_word2, value_word1, value_word0}),
    .key_out   (norm_key),
    .value_out (norm_val)
  );

  lkv_mem u_mem (
    .clk    (clk),
    .req    (req),
    .rd_row (rd_row)
  );

  assign busy    = (state != lkv_pkg::S_IDLE);
  assign idx_inc = lkv_pkg::CNT_W'(idx) + lkv_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lkv_pkg::S_IDLE;
      live_count    <= '0;
      stamp_counter <= '0;
      active_camera <= 8'd1;
      result_valid  <= 1'b0;
    end else begin
      state         <= state_next;
      live_count    <= live_count_next;
      stamp_counter <= stamp_counter_next;
      active_camera <= active_camera_next;
      result_valid  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    op          <= op_next;
    cam         <= cam_next;
    key_r       <= key_r_next;
    val_r       <= val_r_next;
    idx         <= idx_next;
    best        <= best_next;
    slot_r      <= slot_r_next;
    wr_status   <= wr_status_next;
    status      <= e_status;
    slot        <= lkv_pkg::slot_out(e_slot);
    entry_count <= lkv_pkg::count_out(live_count_next);
    out_key0    <= e_key[63:0];
    out_key1    <= e_key[127:64];
    out_key2    <= e_key[191:128];
    out_value0  <= e_val[63:0];
    out_value1  <= e_val[127:64];
    out_value2  <= e_val[191:128];
    out_value3  <= e_val[255:192];
    last        <= e_last;
  end

  always_comb begin
    state_next         = state;
    op_next            = op;
    cam_next           = cam;
    key_r_next         = key_r;
    val_r_next         = val_r;
    live_count_next    = live_count;
    stamp_counter_next = stamp_counter;
    active_camera_next = active_camera;
    idx_next           = idx;
    best_next          = best;
    slot_r_next        = slot_r;
    wr_status_next     = wr_status;

    req.rd_addr       = idx;
    req.wr_en         = 1'b0;
    req.wr_addr       = slot_r;
    req.wr_row.key    = key_r;
    req.wr_row.value  = val_r;
    req.wr_row.stamp  = stamp_counter;

    emit     = 1'b0;
    e_status = lkv_pkg::ST_UPDATED;
    e_slot   = '0;
    e_key    = '0;
    e_val    = '0;
    e_last   = 1'b1;

    case (state)
      lkv_pkg::S_IDLE: begin
        if (start) begin
          op_next    = lkv_pkg::op_t'(opcode);
          cam_next   = camera_id;
          key_r_next = norm_key;
          val_r_next = norm_val;
          state_next = lkv_pkg::S_DECODE;
        end
      end

      lkv_pkg::S_DECODE: begin
        state_next = lkv_pkg::S_IDLE;
        case (op)
          lkv_pkg::OP_STORE: begin
            // The stamp skips zero when it wraps.
            stamp_counter_next = (stamp_counter == '1) ? lkv_pkg::STAMP_W'(1)
                                                        : stamp_counter + 1'b1;
            if (live_count == '0) begin
              slot_r_next    = '0;
              wr_status_next = lkv_pkg::ST_ADDED;
              state_next     = lkv_pkg::S_WRITE;
            end else begin
              idx_next    = '0;
              req.rd_addr = '0;
              state_next  = lkv_pkg::S_SCAN;
            end
          end
          lkv_pkg::OP_DUMP: begin
            if (cam != active_camera || live_count == '0) begin
              emit     = 1'b1;
              e_status = lkv_pkg::ST_DUMP_EMPTY;
            end else begin
              idx_next    = '0;
              req.rd_addr = '0;
              state_next  = lkv_pkg::S_DUMP;
            end
          end
          lkv_pkg::OP_SELECT: begin
            emit = 1'b1;
            if (cam == active_camera) begin
              e_status = lkv_pkg::ST_SAME_CAM;
            end else begin
              live_count_next    = '0;
              stamp_counter_next = '0;
              active_camera_next = cam;
              e_status           = lkv_pkg::ST_CAM_CHANGE;
            end
          end
          lkv_pkg::OP_CLEAR: begin
            live_count_next    = '0;
            stamp_counter_next = '0;
            emit               = 1'b1;
            e_status           = lkv_pkg::ST_CLEARED;
          end
          default: begin
            state_next = lkv_pkg::S_IDLE;
          end
        endcase
      end

      lkv_pkg::S_SCAN: begin
        // The read register holds the row at idx; the next row is fetched
        // in the same cycle.
        if (rd_row.key == key_r) begin
          slot_r_next    = idx;
          wr_status_next = lkv_pkg::ST_UPDATED;
          state_next     = lkv_pkg::S_WRITE;
        end else if (idx_inc == live_count) begin
          if (live_count < lkv_pkg::CNT_W'(lkv_pkg::ENTRIES)) begin
            slot_r_next    = lkv_pkg::IDX_W'(live_count);
            wr_status_next = lkv_pkg::ST_ADDED;
            state_next     = lkv_pkg::S_WRITE;
          end else begin
            idx_next    = '0;
            req.rd_addr = '0;
            state_next  = lkv_pkg::S_MIN;
          end
        end else begin
          idx_next    = lkv_pkg::IDX_W'(idx_inc);
          req.rd_addr = lkv_pkg::IDX_W'(idx_inc);
        end
      end

      lkv_pkg::S_MIN: begin
        // Strict less-than keeps the lowest index on a tie.
        if (idx == '0 || rd_row.stamp < best) begin
          best_next   = rd_row.stamp;
          slot_r_next = idx;
        end
        if (idx_inc == lkv_pkg::CNT_W'(lkv_pkg::ENTRIES)) begin
          wr_status_next = lkv_pkg::ST_REPLACED;
          state_next     = lkv_pkg::S_WRITE;
        end else begin
          idx_next    = lkv_pkg::IDX_W'(idx_inc);
          req.rd_addr = lkv_pkg::IDX_W'(idx_inc);
        end
      end

      lkv_pkg::S_WRITE: begin
        req.wr_en = 1'b1;
        if (wr_status == lkv_pkg::ST_ADDED) begin
          live_count_next = live_count + 1'b1;
        end
        emit       = 1'b1;
        e_status   = wr_status;
        e_slot     = slot_r;
        state_next = lkv_pkg::S_IDLE;
      end

      lkv_pkg::S_DUMP: begin
        emit     = 1'b1;
        e_status = lkv_pkg::ST_DUMP_ENTRY;
        e_slot   = idx;
        e_key    = rd_row.key;
        e_val    = rd_row.value;
        e_last   = (idx_inc == live_count) ||
                   (idx_inc == lkv_pkg::CNT_W'(lkv_pkg::DUMP_N));
        if (e_last) begin
          state_next = lkv_pkg::S_IDLE;
        end else begin
          idx_next    = lkv_pkg::IDX_W'(idx_inc);
          req.rd_addr = lkv_pkg::IDX_W'(idx_inc);
        end
      end

      default: begin
        state_next = lkv_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lkv_norm.sv -----
// String normalizer: zeroes every key and value byte from the first zero
// byte or the length limit on. Depends on lkv_pkg.
module lkv_norm (
  input  lkv_pkg::key_t   key_in,
  input  lkv_pkg::value_t value_in,
  output lkv_pkg::key_t   key_out,
  output lkv_pkg::value_t value_out
);

  always_comb begin
    logic keep;
    keep = 1'b1;
    key_out = '0;
    for (int i = 0; i < lkv_pkg::KEY_WORDS * 8; i++) begin
      keep = keep && (i < lkv_pkg::KEY_BYTES - 1) && (key_in[i*8 +: 8] != 8'd0);
      key_out[i*8 +: 8] = keep ? key_in[i*8 +: 8] : 8'd0;
    end
  end

  always_comb begin
    logic keep;
    keep = 1'b1;
    value_out = '0;
    for (int i = 0; i < lkv_pkg::VALUE_WORDS * 8; i++) begin
      keep = keep && (i < lkv_pkg::VALUE_BYTES - 1) && (value_in[i*8 +: 8] != 8'd0);
      value_out[i*8 +: 8] = keep ? value_in[i*8 +: 8] : 8'd0;
    end
  end

endmodule

// ----- rtl/lkv_mem.sv -----
// Entry memory: one row per table entry holding key, value and write stamp.
// One write port and one registered read port. Depends on lkv_pkg.
module lkv_mem (
  input  logic              clk,
  input  lkv_pkg::mem_req_t req,
  output lkv_pkg::row_t     rd_row
);

  lkv_pkg::row_t mem [lkv_pkg::ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_row;
    end
    rd_row <= mem[req.rd_addr];
  end

endmodule
